/* sv/m61_pkg.sv */
// Shared types, constants and helpers for the modulo 2^61-1 arithmetic unit.
package m61_pkg;

  localparam int unsigned EL_W  = 61;
  localparam int unsigned EXP_W = 64;
  localparam int unsigned FN_W  = 3;

  // Field modulus and the exponent that gives the inverse
  localparam logic [EL_W-1:0]  MOD_P   = 61'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [EXP_W-1:0] INV_EXP = 64'h1FFF_FFFF_FFFF_FFFD;

  // Operation codes
  localparam logic [FN_W-1:0] FN_ADD = 3'd0;
  localparam logic [FN_W-1:0] FN_SUB = 3'd1;
  localparam logic [FN_W-1:0] FN_MUL = 3'd2;
  localparam logic [FN_W-1:0] FN_POW = 3'd3;
  localparam logic [FN_W-1:0] FN_INV = 3'd4;

  // Work class decided by the front end
  typedef enum logic {
    KIND_DIRECT,
    KIND_POW
  } kind_t;

  // Classified command; for direct work a holds the finished result,
  // for power work a is the starting accumulator and b the base
  typedef struct packed {
    kind_t             kind;
    logic              zd;
    logic [EL_W-1:0]   a;
    logic [EL_W-1:0]   b;
    logic [EXP_W-1:0]  e;
  } cmd_t;

  // Destination of a product
  typedef enum logic {
    TAG_BASE,
    TAG_ACC
  } tag_t;

  typedef struct packed {
    logic            valid;
    tag_t            tag;
    logic [EL_W-1:0] x;
    logic [EL_W-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic            valid;
    logic            busy;
    tag_t            tag;
    logic [EL_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_ISSUE_ACC,
    BK_WAIT
  } bk_state_t;

  // Map the one non-canonical code, the modulus itself, to zero
  function automatic logic [EL_W-1:0] fold(input logic [EL_W-1:0] v);
    return (v == MOD_P) ? '0 : v;
  endfunction

endpackage

/* sv/m61_front.sv */
// Front end: reduces operands, computes add and subtract, and classifies each transaction.
module m61_front (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [m61_pkg::FN_W-1:0]   in_func,
  input  logic [m61_pkg::EL_W-1:0]   in_operand_a,
  input  logic [m61_pkg::EL_W-1:0]   in_operand_b,
  input  logic [m61_pkg::EXP_W-1:0]  in_exponent,
  input  logic                       q_full,
  output logic                       q_push,
  output m61_pkg::cmd_t              q_cmd
);

  logic [m61_pkg::EL_W-1:0] a;
  logic [m61_pkg::EL_W-1:0] b;
  logic [m61_pkg::EL_W:0]   sum;
  logic [m61_pkg::EL_W-1:0] add_res;
  logic [m61_pkg::EL_W-1:0] sub_res;

  // Accept whenever the queue has room
  assign in_ready = ~q_full;
  assign q_push   = in_valid & ~q_full;

  // Reduce operands and form the short results
  always_comb begin
    a       = m61_pkg::fold(in_operand_a);
    b       = m61_pkg::fold(in_operand_b);
    sum     = {1'b0, a} + {1'b0, b};
    add_res = (sum >= {1'b0, m61_pkg::MOD_P}) ?
              m61_pkg::EL_W'(sum - {1'b0, m61_pkg::MOD_P}) : sum[m61_pkg::EL_W-1:0];
    sub_res = (a >= b) ? (a - b) :
              m61_pkg::EL_W'({1'b0, a} + {1'b0, m61_pkg::MOD_P} - {1'b0, b});
  end

  // Decode the operation into a command for the back end
  always_comb begin
    q_cmd.kind = m61_pkg::KIND_DIRECT;
    q_cmd.zd   = 1'b0;
    q_cmd.a    = '0;
    q_cmd.b    = '0;
    q_cmd.e    = '0;
    unique case (in_func)
      m61_pkg::FN_ADD: begin
        q_cmd.a = add_res;
      end
      m61_pkg::FN_SUB: begin
        q_cmd.a = sub_res;
      end
      m61_pkg::FN_MUL: begin
        // one step of power with accumulator a and base b gives a*b
        q_cmd.kind = m61_pkg::KIND_POW;
        q_cmd.a    = a;
        q_cmd.b    = b;
        q_cmd.e    = m61_pkg::EXP_W'(1);
      end
      m61_pkg::FN_POW: begin
        q_cmd.kind = m61_pkg::KIND_POW;
        q_cmd.a    = m61_pkg::EL_W'(1);
        q_cmd.b    = a;
        q_cmd.e    = in_exponent;
      end
      m61_pkg::FN_INV: begin
        if (a == '0) begin
          q_cmd.zd = 1'b1;
        end else begin
          q_cmd.kind = m61_pkg::KIND_POW;
          q_cmd.a    = m61_pkg::EL_W'(1);
          q_cmd.b    = a;
          q_cmd.e    = m61_pkg::INV_EXP;
        end
      end
      default: begin
        q_cmd.a = '0;
      end
    endcase
  end

endmodule

/* sv/m61_fifo.sv */
// Command queue between the front end and the back end.
module m61_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  m61_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output m61_pkg::cmd_t head_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  m61_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/m61_mul.sv */
// Four-stage modular multiplier: partial products, product sum, fold, final subtract.
module m61_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  m61_pkg::mul_req_t   req,
  output m61_pkg::mul_rsp_t   rsp
);

  localparam int unsigned W  = m61_pkg::EL_W;
  localparam int unsigned PW = 2 * W;

  logic [3:0]          v_r;
  m61_pkg::tag_t       tag_r [4];
  logic [63:0]         pp_ll_r;
  logic [60:0]         pp_lh_r;
  logic [60:0]         pp_hl_r;
  logic [57:0]         pp_hh_r;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic [W:0]          fold_r, fold_nxt;
  logic [W-1:0]        res_r, res_nxt;
  logic [W:0]          t;

  // Combine partial products, fold high half onto low half, then reduce once
  always_comb begin
    prod_nxt = PW'(pp_ll_r) + (PW'(pp_lh_r) << 32) + (PW'(pp_hl_r) << 32)
             + (PW'(pp_hh_r) << 64);
    fold_nxt = (W+1)'(prod_r[W-1:0]) + (W+1)'(prod_r[PW-1:W]);
    t        = (W+1)'(fold_r[W-1:0]) + (W+1)'(fold_r[W]);
    res_nxt  = (t >= {1'b0, m61_pkg::MOD_P}) ? W'(t - {1'b0, m61_pkg::MOD_P}) : t[W-1:0];
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], req.valid};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    pp_ll_r  <= 64'(req.x[31:0]) * 64'(req.y[31:0]);
    pp_lh_r  <= 61'(req.x[31:0]) * 61'(req.y[60:32]);
    pp_hl_r  <= 61'(req.x[60:32]) * 61'(req.y[31:0]);
    pp_hh_r  <= 58'(req.x[60:32]) * 58'(req.y[60:32]);
    tag_r[0] <= req.tag;
    prod_r   <= prod_nxt;
    tag_r[1] <= tag_r[0];
    fold_r   <= fold_nxt;
    tag_r[2] <= tag_r[1];
    res_r    <= res_nxt;
    tag_r[3] <= tag_r[2];
  end

  assign rsp.valid = v_r[3];
  assign rsp.busy  = |v_r;
  assign rsp.tag   = tag_r[3];
  assign rsp.prod  = res_r;

endmodule

/* sv/m61_back.sv */
// Back end: square-and-multiply sequencer over the shared multiplier, and the output register.
module m61_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  m61_pkg::cmd_t              q_data,
  output logic                       q_pop,
  output m61_pkg::mul_req_t          mul_req,
  input  m61_pkg::mul_rsp_t          mul_rsp,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [m61_pkg::EL_W-1:0]   out_result,
  output logic                       out_zero_divisor
);

  m61_pkg::bk_state_t         state_r, state_nxt;
  logic [m61_pkg::EL_W-1:0]   acc_r, acc_nxt;
  logic [m61_pkg::EL_W-1:0]   base_r, base_nxt;
  logic [m61_pkg::EXP_W-1:0]  exp_r, exp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [m61_pkg::EL_W-1:0]   out_result_r, out_result_nxt;
  logic                       out_zd_r, out_zd_nxt;
  logic                       take;

  // Start a command only when the output register is free
  assign take = q_valid & ~out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      m61_pkg::BK_IDLE: begin
        if (take && q_data.kind == m61_pkg::KIND_POW) begin
          state_nxt = m61_pkg::BK_CHECK;
        end
      end
      m61_pkg::BK_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = m61_pkg::BK_IDLE;
        end else if (exp_r[0]) begin
          state_nxt = m61_pkg::BK_ISSUE_ACC;
        end else begin
          state_nxt = m61_pkg::BK_WAIT;
        end
      end
      m61_pkg::BK_ISSUE_ACC: begin
        state_nxt = m61_pkg::BK_WAIT;
      end
      m61_pkg::BK_WAIT: begin
        if (!mul_rsp.busy) begin
          state_nxt = m61_pkg::BK_CHECK;
        end
      end
      default: begin
        state_nxt = m61_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs and datapath
  always_comb begin
    q_pop          = 1'b0;
    mul_req        = '0;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_result_nxt = out_result_r;
    out_zd_nxt     = out_zd_r;

    // write back returning products
    if (mul_rsp.valid) begin
      if (mul_rsp.tag == m61_pkg::TAG_ACC) begin
        acc_nxt = mul_rsp.prod;
      end else begin
        base_nxt = mul_rsp.prod;
      end
    end

    unique case (state_r)
      m61_pkg::BK_IDLE: begin
        if (take) begin
          q_pop = 1'b1;
          if (q_data.kind == m61_pkg::KIND_DIRECT) begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = q_data.a;
            out_zd_nxt     = q_data.zd;
          end else begin
            acc_nxt  = q_data.a;
            base_nxt = q_data.b;
            exp_nxt  = q_data.e;
          end
        end
      end
      m61_pkg::BK_CHECK: begin
        if (exp_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          out_zd_nxt     = 1'b0;
        end else begin
          mul_req.valid = 1'b1;
          mul_req.tag   = m61_pkg::TAG_BASE;
          mul_req.x     = base_r;
          mul_req.y     = base_r;
        end
      end
      m61_pkg::BK_ISSUE_ACC: begin
        // base is still the old value: its square is in flight
        mul_req.valid = 1'b1;
        mul_req.tag   = m61_pkg::TAG_ACC;
        mul_req.x     = acc_r;
        mul_req.y     = base_r;
      end
      m61_pkg::BK_WAIT: begin
        if (!mul_rsp.busy) begin
          exp_nxt = exp_r >> 1;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= m61_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    base_r       <= base_nxt;
    exp_r        <= exp_nxt;
    out_result_r <= out_result_nxt;
    out_zd_r     <= out_zd_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_zero_divisor = out_zd_r;

endmodule

/* sv/mersenne61_modular_alu.sv */
// Arithmetic unit modulo 2^61-1: add, subtract, multiply, power and inverse.
// The front end folds operands (the modulus reads as zero), finishes add, subtract,
// unknown codes and the inverse of zero at once, and queues up to QUEUE_DEPTH
// classified transactions. The back end runs one transaction at a time and starts the
// next only once the output register is empty. Power scans the exponent from its lowest bit
// up to the highest set bit: each bit squares the base, and a set bit also multiplies
// the accumulator by the old base. Inverse uses the exponent 2^61-3, which has 60 set
// bits and one clear bit. Each exponent bit waits on the four-stage multiplier: both
// products of one exponent bit must return before the next bit starts. A zero
// exponent gives 1; the inverse of zero gives 0 with zero_divisor high.
module mersenne61_modular_alu #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [m61_pkg::FN_W-1:0]   in_func,
  input  logic [m61_pkg::EL_W-1:0]   in_operand_a,
  input  logic [m61_pkg::EL_W-1:0]   in_operand_b,
  input  logic [m61_pkg::EXP_W-1:0]  in_exponent,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [m61_pkg::EL_W-1:0]   out_result,
  output logic                       out_zero_divisor
);

  logic              q_full;
  logic              q_push;
  m61_pkg::cmd_t     q_cmd;
  logic              q_pop;
  logic              q_valid;
  m61_pkg::cmd_t     q_head;
  m61_pkg::mul_req_t mul_req;
  m61_pkg::mul_rsp_t mul_rsp;

  m61_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_exponent  (in_exponent),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  m61_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  m61_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  m61_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_head),
    .q_pop            (q_pop),
    .mul_req          (mul_req),
    .mul_rsp          (mul_rsp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result       (out_result),
    .out_zero_divisor (out_zero_divisor)
  );

endmodule

/* sv/m61_checker.sv */
// Port-level checks for the arithmetic unit and the bind that attaches them.
module m61_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [m61_pkg::EL_W-1:0] out_result,
  input logic                     out_zero_divisor
);

  // Hold an offered input transaction until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("offered input withdrawn");

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_zero_divisor))
    else $error("stalled result changed");

  // Results are always canonical
  a_out_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result != m61_pkg::MOD_P)
    else $error("result not reduced");

  // Zero divisor comes with a zero result
  a_zd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_divisor |-> out_result == '0)
    else $error("zero divisor with nonzero result");

  // Drop any result during reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mersenne61_modular_alu m61_checker u_m61_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result       (out_result),
  .out_zero_divisor (out_zero_divisor)
);
